[rtl/u16u8_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and encode helpers of the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_UNIT_LIMIT = 2'd0,
        REG_BYTE_LIMIT = 2'd1
    } cfg_reg_t;

    localparam logic [6:0] UNIT_LIMIT_RST = 7'd32;
    localparam logic [7:0] BYTE_LIMIT_RST = 8'd127;

    // default job queue depth
    localparam int JOB_QUEUE_DEPTH = 4;

    // code unit classes
    localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
    localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;
    localparam logic [15:0] REPL_CHAR    = 16'hFFFD;

    // encoded lengths
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_1    = 3'd1;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    // work item handed from the front to the back: up to two code points
    // (slot a, then slot b) and an optional end beat
    typedef struct packed {
        logic [20:0] cp_a;
        logic [2:0]  len_a;
        logic [15:0] cp_b;
        logic [1:0]  len_b;
        logic        has_end;
        logic        empty;
    } job_t;

    // UTF-8 length of a code point
    function automatic logic [2:0] cp_len(input logic [20:0] cp);
        logic [2:0] n;
        if (cp < 21'h80)
            n = LEN_1;
        else if (cp < 21'h800)
            n = LEN_2;
        else if (cp < 21'h10000)
            n = LEN_3;
        else
            n = LEN_4;
        return n;
    endfunction

    // byte k of the UTF-8 encoding of cp, which takes len bytes
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                             input logic [2:0] len,
                                             input logic [1:0] k);
        logic [7:0] b;
        b = 8'h00;
        unique case (len)
            LEN_2:
            begin
                b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            end
            LEN_3:
            begin
                unique case (k)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            LEN_4:
            begin
                unique case (k)
                    2'd0: b = {5'b11110, cp[20:18]};
                    2'd1: b = {2'b10, cp[17:12]};
                    2'd2: b = {2'b10, cp[11:6]};
                    2'd3: b = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                b = {1'b0, cp[6:0]};
            end
        endcase
        return b;
    endfunction

endpackage

[rtl/u16u8_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_front
// Decodes one code unit per beat: surrogate pairing, unit and byte limits,
// string end. Emits a job describing the code points to encode.
// ----------------------------------------------------------------------------
module u16u8_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [15:0]         code_unit,
    input  logic                first_unit,
    input  logic [6:0]          unit_limit,
    input  logic [7:0]          byte_limit,
    output u16u8_pkg::job_t     job,
    output logic                job_push
);
    import u16u8_pkg::*;

    typedef struct packed {
        logic       ok;
        logic [7:0] be;
        logic       stop;
    } emit_t;

    logic        pending_valid_reg, pending_valid_next;
    logic [9:0]  pending_high_bits_reg, pending_high_bits_next;
    logic [7:0]  bytes_emitted_reg, bytes_emitted_next;
    logic [6:0]  units_seen_reg, units_seen_next;
    logic        output_stopped_reg, output_stopped_next;

    // byte budget check for one code point of n bytes
    function automatic emit_t try_emit(input logic [7:0] be, input logic stop,
                                       input logic [7:0] limit,
                                       input logic [2:0] n);
        emit_t r;
        logic [8:0] sum;
        sum = {1'b0, be} + {6'b0, n};
        r.ok = 1'b0;
        r.be = be;
        r.stop = stop;
        if (!stop)
        begin
            if (sum > {1'b0, limit})
                r.stop = 1'b1;
            else
            begin
                r.ok = 1'b1;
                r.be = sum[7:0];
            end
        end
        return r;
    endfunction

    // decode of the current unit against string state
    always_comb
    begin
        logic        pv;
        logic [9:0]  phb;
        logic [7:0]  be;
        logic [6:0]  us;
        logic        stp;
        logic        handle;
        logic        is_high;
        logic        is_low;
        logic [20:0] pair_cp;
        logic [2:0]  n_b;
        emit_t       e;

        e   = '0;
        pv  = pending_valid_reg;
        phb = pending_high_bits_reg;
        be  = bytes_emitted_reg;
        us  = units_seen_reg;
        stp = output_stopped_reg;
        if (first_unit)
        begin
            pv  = 1'b0;
            phb = '0;
            be  = '0;
            us  = '0;
            stp = 1'b0;
        end

        is_high = (code_unit >= HIGH_SURR_LO) && (code_unit <= HIGH_SURR_HI);
        is_low  = (code_unit >= LOW_SURR_LO) && (code_unit <= LOW_SURR_HI);
        pair_cp = SUPP_BASE + {1'b0, phb, code_unit[9:0]};
        n_b     = cp_len({5'b0, code_unit});
        handle  = 1'b1;
        job     = '0;

        if (code_unit == 16'h0000)
        begin
            // terminator: flush held surrogate, then end beat
            if (pv)
            begin
                e = try_emit(be, stp, byte_limit, LEN_3);
                if (e.ok)
                begin
                    job.cp_a  = {5'b0, REPL_CHAR};
                    job.len_a = LEN_3;
                end
                be  = e.be;
                stp = e.stop;
            end
            job.has_end = 1'b1;
            job.empty   = (be == 8'd0);
            pv  = 1'b0;
            phb = '0;
            be  = '0;
            us  = '0;
            stp = 1'b0;
        end
        else
        begin
            // held high surrogate: join or flush
            if (pv)
            begin
                pv = 1'b0;
                if (is_low)
                begin
                    e = try_emit(be, stp, byte_limit, LEN_4);
                    if (e.ok)
                    begin
                        job.cp_a  = pair_cp;
                        job.len_a = LEN_4;
                    end
                    if (us != 7'd127)
                        us = us + 7'd1;
                    handle = 1'b0;
                end
                else
                begin
                    e = try_emit(be, stp, byte_limit, LEN_3);
                    if (e.ok)
                    begin
                        job.cp_a  = {5'b0, REPL_CHAR};
                        job.len_a = LEN_3;
                    end
                    if (e.stop)
                        handle = 1'b0;
                end
                be  = e.be;
                stp = e.stop;
                phb = '0;
            end

            // the unit on its own
            if (handle && !stp && (us < unit_limit))
            begin
                us = us + 7'd1;
                if (is_high)
                begin
                    pv  = 1'b1;
                    phb = code_unit[9:0];
                end
                else
                begin
                    e = try_emit(be, stp, byte_limit, is_low ? LEN_3 : n_b);
                    if (e.ok)
                    begin
                        job.cp_b  = is_low ? REPL_CHAR : code_unit;
                        job.len_b = is_low ? 2'd3 : n_b[1:0];
                    end
                    be  = e.be;
                    stp = e.stop;
                end
            end
        end

        pending_valid_next     = pv;
        pending_high_bits_next = phb;
        bytes_emitted_next     = be;
        units_seen_next        = us;
        output_stopped_next    = stp;
        job_push = fire && ((job.len_a != LEN_NONE) || (job.len_b != 2'd0) || job.has_end);
    end

    // string state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_valid_reg     <= 1'b0;
            pending_high_bits_reg <= '0;
            bytes_emitted_reg     <= '0;
            units_seen_reg        <= '0;
            output_stopped_reg    <= 1'b0;
        end
        else if (fire)
        begin
            pending_valid_reg     <= pending_valid_next;
            pending_high_bits_reg <= pending_high_bits_next;
            bytes_emitted_reg     <= bytes_emitted_next;
            units_seen_reg        <= units_seen_next;
            output_stopped_reg    <= output_stopped_next;
        end
    end

endmodule

[rtl/u16u8_job_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_job_queue
// Small FIFO of decoded jobs between the front and the back.
// ----------------------------------------------------------------------------
module u16u8_job_queue #(
    parameter int DEPTH = u16u8_pkg::JOB_QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  u16u8_pkg::job_t push_job,
    input  logic            pop,
    output u16u8_pkg::job_t head_job,
    output logic            not_empty,
    output logic            full
);
    import u16u8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_job  = slots_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

endmodule

[rtl/u16u8_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_back
// Walks the head job one result beat per cycle, while the output is not stalled,
// and encodes UTF-8 bytes into the output register.
// ----------------------------------------------------------------------------
module u16u8_back (
    input  logic            clk,
    input  logic            rst_n,
    input  u16u8_pkg::job_t job,
    input  logic            job_valid,
    output logic            job_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            end_of_string,
    output logic            string_empty,
    output logic            last_of_run
);
    import u16u8_pkg::*;

    logic [2:0] pos_reg, pos_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       eos_reg, eos_next;
    logic       empty_reg, empty_next;
    logic       last_reg, last_next;
    logic       load;

    // beat selection within the job
    always_comb
    begin
        logic [3:0] len_ab;
        logic [3:0] total;
        logic [2:0] pos_b;
        logic       is_last;

        len_ab  = {1'b0, job.len_a} + {2'b0, job.len_b};
        total   = len_ab + {3'b0, job.has_end};
        pos_b   = pos_reg - job.len_a;
        is_last = ({1'b0, pos_reg} + 4'd1 == total);

        load = job_valid && (!out_valid_reg || out_ready);

        byte_next  = 8'h00;
        eos_next   = 1'b0;
        empty_next = 1'b0;
        last_next  = is_last;
        if (pos_reg < job.len_a)
            byte_next = utf8_byte(job.cp_a, job.len_a, pos_reg[1:0]);
        else if ({1'b0, pos_reg} < len_ab)
            byte_next = utf8_byte({5'b0, job.cp_b}, {1'b0, job.len_b}, pos_b[1:0]);
        else
        begin
            eos_next   = 1'b1;
            empty_next = job.empty;
        end

        pos_pop_logic:
        begin
            pos_next = pos_reg;
            job_pop  = 1'b0;
            if (load)
            begin
                if (is_last)
                begin
                    pos_next = '0;
                    job_pop  = 1'b1;
                end
                else
                    pos_next = pos_reg + 3'd1;
            end
        end

        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= byte_next;
            eos_reg   <= eos_next;
            empty_reg <= empty_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = byte_reg;
    assign end_of_string = eos_reg;
    assign string_empty  = empty_reg;
    assign last_of_run   = last_reg;

endmodule

[rtl/utf16_to_utf8_transcoder.sv]
`timescale 1ns / 1ps
// An accepted unit's job is written into the job queue; the back then registers
// its first result beat in the output register. Throughput: one unit per cycle
// enters while the job queue has room; results leave at one beat per cycle while
// out_ready is high, and a unit gives 0 to 6 result beats. The byte-wide output
// register sets the sustained rate.
// Reset: string state cleared, unit_limit 32, byte_limit 127, queue and output empty.
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Top level: config registers, decode front, job queue and encode back.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = u16u8_pkg::JOB_QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [15:0]                      code_unit,
    input  logic                             first_unit,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       out_byte,
    output logic                             end_of_string,
    output logic                             string_empty,
    output logic                             last_of_run,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [u16u8_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [u16u8_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import u16u8_pkg::*;

    logic [6:0] unit_limit_reg;
    logic [7:0] byte_limit_reg;
    logic       in_fire;
    job_t       new_job;
    job_t       head_job;
    logic       job_push;
    logic       job_pop;
    logic       queue_not_empty;
    logic       queue_full;

    assign cfg_ready = 1'b1;
    assign in_ready  = !queue_full;
    assign in_fire   = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_limit_reg <= UNIT_LIMIT_RST;
            byte_limit_reg <= BYTE_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_UNIT_LIMIT)
                unit_limit_reg <= cfg_data[6:0];
            else if (cfg_index == REG_BYTE_LIMIT)
                byte_limit_reg <= cfg_data;
        end
    end

    u16u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (in_fire),
        .code_unit  (code_unit),
        .first_unit (first_unit),
        .unit_limit (unit_limit_reg),
        .byte_limit (byte_limit_reg),
        .job        (new_job),
        .job_push   (job_push)
    );

    u16u8_job_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (new_job),
        .pop       (job_pop),
        .head_job  (head_job),
        .not_empty (queue_not_empty),
        .full      (queue_full)
    );

    u16u8_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (head_job),
        .job_valid     (queue_not_empty),
        .job_pop       (job_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .end_of_string (end_of_string),
        .string_empty  (string_empty),
        .last_of_run   (last_of_run)
    );

endmodule

[rtl/u16u8_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_checker
// Port-level checks of the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
module u16u8_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        end_of_string,
    input logic        string_empty,
    input logic        last_of_run
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(last_of_run))
        else $error("stalled result beat changed");

    // end beat closes the run of its unit
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_string |-> last_of_run && (out_byte == 8'h00))
        else $error("end beat not last or carries a byte");

    // byte beats never flag an empty string
    a_byte_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !end_of_string |-> !string_empty)
        else $error("byte beat flagged empty");

    // an end beat with bytes before it in the string cannot report empty
    a_empty_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !end_of_string && !last_of_run
            |=> !(out_valid && end_of_string && string_empty))
        else $error("empty string reported after byte");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (.*);

[tb/sv/tb_utf16_to_utf8_transcoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_transcoder
// Self-checking bench for the UTF-16 to UTF-8 transcoder. A directed table
// covers encoding extremes, surrogate pairing and the limit corner cases; then
// random strings run under several limit settings and stall profiles. Each
// output beat is checked against table bytes or a local model of the transcoder.
// ----------------------------------------------------------------------------
module tb_utf16_to_utf8_transcoder;
    import u16u8_pkg::*;

    localparam int          SETTLE_CYCLES = 16;
    localparam int          LONG_HOLD     = 80;
    localparam int          BATCH_UNITS   = 4;
    localparam int          NUM_BATCHES   = 9;
    localparam int          MAX_BEATS     = 6;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [6:0]  UNITS_SAT     = 7'd127;
    localparam logic [1:0]  REG_SPARE_2   = 2'd2;
    localparam logic [1:0]  REG_SPARE_3   = 2'd3;
    localparam logic [20:0] REPL_CP       = {5'd0, REPL_CHAR};

    // one output beat
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic       empty;
        logic       last;
    } utf8_beat_t;

    // directed table
    typedef enum logic [1:0] {STEP_UNIT, STEP_LIT, STEP_CFG} step_kind_t;
    typedef enum logic [1:0] {LAST_DATA, LAST_END, LAST_END_EMPTY} tail_t;

    typedef struct packed {
        step_kind_t                 kind;
        logic [CFG_INDEX_W-1:0]     reg_idx;
        logic [CFG_DATA_W-1:0]      reg_val;
        logic [15:0]                unit;
        logic                       first;
        logic [2:0]                 n;      // literal beat count
        logic [47:0]                bytes;  // literal bytes, right aligned, in order
        tail_t                      tail;
    } dir_row_t;

    localparam int DIR_COUNT = 33;
    localparam dir_row_t DIR_STEPS [DIR_COUNT] = '{
        // reset limits: encoding extremes
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'h0041, 1'b1, 3'd1, 48'h41,       LAST_DATA},
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'h007F, 1'b0, 3'd1, 48'h7F,       LAST_DATA},
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'h0080, 1'b0, 3'd2, 48'hC280,     LAST_DATA},
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'h07FF, 1'b0, 3'd2, 48'hDFBF,     LAST_DATA},
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'hFFFF, 1'b0, 3'd3, 48'hEFBFBF,   LAST_DATA},
        // surrogate pairs at both ends of the range
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'hD800, 1'b0, 3'd0, 48'h0,        LAST_DATA},
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'hDC00, 1'b0, 3'd4, 48'hF0908080, LAST_DATA},
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'hDBFF, 1'b0, 3'd0, 48'h0,        LAST_DATA},
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'hDFFF, 1'b0, 3'd4, 48'hF48FBFBF, LAST_DATA},
        // lone low, high after high, high before plain unit
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'hDC00, 1'b0, 3'd3, 48'hEFBFBD,   LAST_DATA},
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'hD83D, 1'b0, 3'd0, 48'h0,        LAST_DATA},
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'hD802, 1'b0, 3'd3, 48'hEFBFBD,   LAST_DATA},
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'h0042, 1'b0, 3'd4, 48'hEFBFBD42, LAST_DATA},
        // terminator flushes a held high, then an empty string
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'hD800, 1'b0, 3'd0, 48'h0,        LAST_DATA},
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'h0000, 1'b0, 3'd4, 48'hEFBFBD00, LAST_END},
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'h0000, 1'b0, 3'd1, 48'h00,       LAST_END_EMPTY},
        // first_unit drops a held high silently
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'hD800, 1'b1, 3'd0, 48'h0,        LAST_DATA},
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'h0800, 1'b1, 3'd3, 48'hE0A080,   LAST_DATA},
        // tight limits: pairing past the unit limit, byte limit stop
        '{STEP_CFG,  REG_UNIT_LIMIT, 8'h02, 16'h0000, 1'b0, 3'd0, 48'h0,        LAST_DATA},
        '{STEP_CFG,  REG_BYTE_LIMIT, 8'h04, 16'h0000, 1'b0, 3'd0, 48'h0,        LAST_DATA},
        '{STEP_UNIT, REG_UNIT_LIMIT, 8'h00, 16'h0061, 1'b1, 3'd0, 48'h0,        LAST_DATA},
        '{STEP_UNIT, REG_UNIT_LIMIT, 8'h00, 16'hD800, 1'b0, 3'd0, 48'h0,        LAST_DATA},
        '{STEP_UNIT, REG_UNIT_LIMIT, 8'h00, 16'hDC05, 1'b0, 3'd0, 48'h0,        LAST_DATA},
        '{STEP_UNIT, REG_UNIT_LIMIT, 8'h00, 16'h0062, 1'b0, 3'd0, 48'h0,        LAST_DATA},
        '{STEP_UNIT, REG_UNIT_LIMIT, 8'h00, 16'h0000, 1'b0, 3'd0, 48'h0,        LAST_DATA},
        // replacement flush overruns the byte limit
        '{STEP_UNIT, REG_UNIT_LIMIT, 8'h00, 16'h0800, 1'b0, 3'd0, 48'h0,        LAST_DATA},
        '{STEP_UNIT, REG_UNIT_LIMIT, 8'h00, 16'hD800, 1'b0, 3'd0, 48'h0,        LAST_DATA},
        '{STEP_UNIT, REG_UNIT_LIMIT, 8'h00, 16'h0041, 1'b0, 3'd0, 48'h0,        LAST_DATA},
        '{STEP_UNIT, REG_UNIT_LIMIT, 8'h00, 16'h0000, 1'b0, 3'd0, 48'h0,        LAST_DATA},
        // unit limit of zero (bit 7 dropped), spare index ignored
        '{STEP_CFG,  REG_UNIT_LIMIT, 8'h80, 16'h0000, 1'b0, 3'd0, 48'h0,        LAST_DATA},
        '{STEP_CFG,  REG_SPARE_3,    8'hFF, 16'h0000, 1'b0, 3'd0, 48'h0,        LAST_DATA},
        '{STEP_UNIT, REG_UNIT_LIMIT, 8'h00, 16'h0041, 1'b0, 3'd0, 48'h0,        LAST_DATA},
        '{STEP_LIT,  REG_UNIT_LIMIT, 8'h00, 16'h0000, 1'b0, 3'd1, 48'h00,       LAST_END_EMPTY}
    };

    // DUT ports
    logic                   clk;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   in_ready;
    logic [15:0]            code_unit   = '0;
    logic                   first_unit  = 1'b0;
    logic                   out_valid;
    logic                   out_ready   = 1'b0;
    logic [7:0]             out_byte;
    logic                   end_of_string;
    logic                   string_empty;
    logic                   last_of_run;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;

    // model state
    logic [6:0] cur_unit_limit;
    logic [7:0] cur_byte_limit;
    logic       held_valid;
    logic [9:0] held_bits;
    logic [7:0] bytes_out;
    logic [6:0] units_taken;
    logic       output_halted;

    utf8_beat_t run_beats[$];
    utf8_beat_t literal_beats[$];
    utf8_beat_t beats_due[$];

    int  fail_count    = 0;
    int  units_sent    = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  long_hold_req = 1'b0;

    utf16_to_utf8_transcoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .code_unit     (code_unit),
        .first_unit    (first_unit),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .end_of_string (end_of_string),
        .string_empty  (string_empty),
        .last_of_run   (last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // transcoder model
    // ------------------------------------------------------------------
    function automatic void clear_string_state();
        held_valid    = 1'b0;
        held_bits     = '0;
        bytes_out     = '0;
        units_taken   = '0;
        output_halted = 1'b0;
    endfunction

    function automatic void add_beat(input logic [7:0] b, input logic eos, input logic empty);
        if (run_beats.size() < MAX_BEATS)
            run_beats.push_back('{data: b, eos: eos, empty: empty, last: 1'b0});
    endfunction

    // a code point that would overrun the byte limit is dropped whole
    function automatic void put_code_point(input logic [20:0] cp);
        int n;
        if (output_halted)
            return;
        n = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
        if (int'(bytes_out) + n > int'(cur_byte_limit))
        begin
            output_halted = 1'b1;
            return;
        end
        case (n)
            1: add_beat(cp[7:0], 1'b0, 1'b0);
            2:
            begin
                add_beat({3'b110, cp[10:6]}, 1'b0, 1'b0);
                add_beat({2'b10, cp[5:0]}, 1'b0, 1'b0);
            end
            3:
            begin
                add_beat({4'b1110, cp[15:12]}, 1'b0, 1'b0);
                add_beat({2'b10, cp[11:6]}, 1'b0, 1'b0);
                add_beat({2'b10, cp[5:0]}, 1'b0, 1'b0);
            end
            default:
            begin
                add_beat({5'b11110, cp[20:18]}, 1'b0, 1'b0);
                add_beat({2'b10, cp[17:12]}, 1'b0, 1'b0);
                add_beat({2'b10, cp[11:6]}, 1'b0, 1'b0);
                add_beat({2'b10, cp[5:0]}, 1'b0, 1'b0);
            end
        endcase
        bytes_out = bytes_out + 8'(n);
    endfunction

    function automatic void predict_unit(input logic [15:0] cu, input logic first);
        logic       go;
        utf8_beat_t tail;
        run_beats.delete();
        if (first)
            clear_string_state();
        if (cu == 16'h0000)
        begin
            if (held_valid)
                put_code_point(REPL_CP);
            add_beat(8'h00, 1'b1, bytes_out == 8'd0);
            clear_string_state();
        end
        else
        begin
            go = 1'b1;
            // unit after a held high is always checked for pairing
            if (held_valid)
            begin
                held_valid = 1'b0;
                if (cu >= LOW_SURR_LO && cu <= LOW_SURR_HI)
                begin
                    put_code_point(SUPP_BASE + {1'b0, held_bits, cu[9:0]});
                    if (units_taken < UNITS_SAT)
                        units_taken = units_taken + 7'd1;
                    go = 1'b0;
                end
                else
                begin
                    put_code_point(REPL_CP);
                    if (output_halted)
                        go = 1'b0;
                end
                held_bits = '0;
            end
            if (go && !output_halted && units_taken < cur_unit_limit)
            begin
                units_taken = units_taken + 7'd1;
                if (cu >= HIGH_SURR_LO && cu <= HIGH_SURR_HI)
                begin
                    held_valid = 1'b1;
                    held_bits  = cu[9:0];
                end
                else if (cu >= LOW_SURR_LO && cu <= LOW_SURR_HI)
                    put_code_point(REPL_CP);
                else
                    put_code_point({5'd0, cu});
            end
        end
        if (run_beats.size() != 0)
        begin
            tail = run_beats.pop_back();
            tail.last = 1'b1;
            run_beats.push_back(tail);
        end
    endfunction

    function automatic void load_literal(input dir_row_t r);
        utf8_beat_t b;
        int         cnt;
        literal_beats.delete();
        cnt = int'(r.n);
        for (int k = 0; k < cnt; k++)
        begin
            b.data  = r.bytes[8*(cnt-1-k) +: 8];
            b.last  = (k == cnt - 1);
            b.eos   = b.last && (r.tail != LAST_DATA);
            b.empty = b.last && (r.tail == LAST_END_EMPTY);
            literal_beats.push_back(b);
        end
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // valid stays high across back-to-back units; it drops only on a gap
    task automatic send_unit(input logic [15:0] cu, input logic first, input bit use_literal);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        code_unit  <= cu;
        first_unit <= first;
        do
            @(posedge clk);
        while (!in_ready);
        units_sent++;
        predict_unit(cu, first);
        if (use_literal)
            foreach (literal_beats[k]) beats_due.push_back(literal_beats[k]);
        else
            foreach (run_beats[k]) beats_due.push_back(run_beats[k]);
    endtask

    // caller lowers cfg_valid after the last write of a group
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_UNIT_LIMIT)
            cur_unit_limit = val[6:0];
        else if (idx == REG_BYTE_LIMIT)
            cur_byte_limit = val;
    endtask

    // units that give no beat may still be in flight; let them drain
    task automatic settle();
        in_valid <= 1'b0;
        while (beats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly well-formed strings with random content, some noise
    task automatic send_random_string();
        int          len;
        int          kind;
        logic        first;
        logic [15:0] cu;
        logic [15:0] lo;
        len   = ($urandom_range(5) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
        first = ($urandom_range(3) != 0);
        for (int k = 0; k < len; k++)
        begin
            kind = $urandom_range(9);
            case (kind)
                0, 1, 2: cu = 16'($urandom_range(1, 127));
                3:       cu = 16'($urandom_range(128, 2047));
                4:       cu = 16'($urandom_range(2048, 16'hD7FF));
                5:       cu = 16'($urandom_range(16'hE000, 16'hFFFF));
                6, 7:    cu = 16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI));
                8:       cu = 16'($urandom_range(HIGH_SURR_LO, LOW_SURR_HI));
                default: cu = 16'($urandom_range(1, 16'hFFFF));
            endcase
            send_unit(cu, first, 1'b0);
            // a proper pair after every high from kinds 6 and 7
            if (kind == 6 || kind == 7)
            begin
                lo = 16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI));
                send_unit(lo, 1'b0, 1'b0);
            end
            first = ($urandom_range(19) == 0);
        end
        if ($urandom_range(9) != 0)
            send_unit(16'h0000, first, 1'b0);
    endtask

    // fills the unit counter to its ceiling, then pairs a surrogate
    task automatic send_saturating_string();
        send_unit(16'($urandom_range(1, 127)), 1'b1, 1'b0);
        for (int k = 1; k < 126; k++)
            send_unit(16'($urandom_range(1, 127)), 1'b0, 1'b0);
        send_unit(16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI)), 1'b0, 1'b0);
        send_unit(16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI)), 1'b0, 1'b0);
        send_unit(16'($urandom_range(1, 127)), 1'b0, 1'b0);
        send_unit(16'h0000, 1'b0, 1'b0);
    endtask

    task automatic configure_batch(input int b);
        logic [7:0] ul;
        logic [7:0] bl;
        case (b)
            0:       begin ul = 8'd32;  bl = 8'd127; end
            1:       begin ul = 8'd1;   bl = 8'd4;   end
            2:       begin ul = 8'd64;  bl = 8'd255; end
            4:       begin ul = 8'd3;   bl = 8'd2;   end
            5:       begin ul = 8'h7F;  bl = 8'd255; end
            6:       begin ul = 8'($urandom_range(255)); bl = 8'($urandom_range(255)); end
            7:       begin ul = 8'd64;  bl = 8'd4;   end
            8:       begin ul = 8'd1;   bl = 8'd255; end
            default: begin ul = 8'($urandom_range(1, 64)); bl = 8'($urandom_range(4, 255)); end
        endcase
        settle();
        write_reg(REG_UNIT_LIMIT, ul);
        write_reg(REG_BYTE_LIMIT, bl);
        if (b == 6)
            write_reg(REG_SPARE_2, 8'($urandom_range(255)));
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // output side: stalls and beat checking
    // ------------------------------------------------------------------
    task automatic log_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t ns: %s", $time, what);
    endtask

    task automatic check_beat();
        utf8_beat_t want;
        if (beats_due.size() == 0)
        begin
            log_failure($sformatf("unexpected beat: byte %02h eos %0b empty %0b last %0b",
                                  out_byte, end_of_string, string_empty, last_of_run));
        end
        else
        begin
            want = beats_due.pop_front();
            if (out_byte !== want.data || end_of_string !== want.eos ||
                string_empty !== want.empty || last_of_run !== want.last)
                log_failure($sformatf({"beat mismatch: exp byte %02h eos %0b empty %0b last %0b,",
                                       " got byte %02h eos %0b empty %0b last %0b"},
                                      want.data, want.eos, want.empty, want.last,
                                      out_byte, end_of_string, string_empty, last_of_run));
        end
    endtask

    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                check_beat();
            // one long back-pressure stretch so the input side stalls
            if (long_hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int start;
        cur_unit_limit = UNIT_LIMIT_RST;
        cur_byte_limit = BYTE_LIMIT_RST;
        clear_string_state();
        send_idle_pct = 24;
        recv_idle_pct = 58;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_COUNT; i++)
        begin
            if (DIR_STEPS[i].kind == STEP_CFG)
            begin
                if (i == 0 || DIR_STEPS[i-1].kind != STEP_CFG)
                    settle();
                write_reg(DIR_STEPS[i].reg_idx, DIR_STEPS[i].reg_val);
                if (i == DIR_COUNT - 1 || DIR_STEPS[i+1].kind != STEP_CFG)
                    cfg_valid <= 1'b0;
            end
            else
            begin
                load_literal(DIR_STEPS[i]);
                send_unit(DIR_STEPS[i].unit, DIR_STEPS[i].first, DIR_STEPS[i].kind == STEP_LIT);
            end
        end

        // random batches: three stall profiles, three limit settings each
        for (int b = 0; b < NUM_BATCHES; b++)
        begin
            configure_batch(b);
            if (b < 3)
            begin
                send_idle_pct = 24;
                recv_idle_pct = 58;
            end
            else if (b < 6)
            begin
                send_idle_pct = 58;
                recv_idle_pct = 24;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (b == 6)
                long_hold_req = 1'b1;
            if (b == 5)
                send_saturating_string();
            else
            begin
                start = units_sent;
                while (units_sent - start < BATCH_UNITS)
                    send_random_string();
            end
        end

        settle();
        if (fail_count == 0 && beats_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
